@@ rtl/core/wsd_pkg.sv @@
// Shared types and constants for the work-stealing deque unit.
package wsd_pkg;

  localparam int TASK_W     = 64;
  localparam int FILL_OUT_W = 6;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUT   = 2'd0,
    OP_TAKE  = 2'd1,
    OP_STEAL = 2'd2,
    OP_NONE  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Memory request and result status that the index control hands to the top.
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    status_t status;
  } wsd_req_t;

endpackage

@@ rtl/core/wsd_ram.sv @@
// Generic single-port RAM with a registered read port that holds when not read.
module wsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/wsd_ctrl.sv @@
// Head and tail index control: fill, full and empty checks and the memory request.
module wsd_ctrl #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH),
  parameter int FW    = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_valid,
  input  wsd_pkg::func_t    func,
  output wsd_pkg::wsd_req_t req,
  output logic [AW-1:0]     addr,
  output logic [FW-1:0]     fill_after
);
  import wsd_pkg::*;

  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [FW-1:0] DepthF   = FW'(DEPTH);

  // Each index is a slot within the ring plus a lap bit, which together
  // count modulo twice the depth.
  logic [AW-1:0] head_slot_r, head_slot_nxt;
  logic          head_lap_r, head_lap_nxt;
  logic [AW-1:0] tail_slot_r, tail_slot_nxt;
  logic          tail_lap_r, tail_lap_nxt;

  logic [FW-1:0] fill;
  logic          full;
  logic          empty;
  logic [AW-1:0] tail_dec_slot;
  logic          tail_dec_lap;
  logic [AW-1:0] tail_inc_slot;
  logic          tail_inc_lap;
  logic [AW-1:0] head_inc_slot;
  logic          head_inc_lap;

  always_comb begin
    fill = FW'(tail_slot_r) - FW'(head_slot_r);
    if (tail_lap_r != head_lap_r) begin
      fill = fill + DepthF;
    end
  end

  assign full  = (fill == DepthF);
  assign empty = (fill == '0);

  assign tail_inc_slot = (tail_slot_r == LastSlot) ? '0 : tail_slot_r + AW'(1);
  assign tail_inc_lap  = (tail_slot_r == LastSlot) ? ~tail_lap_r : tail_lap_r;
  assign tail_dec_slot = (tail_slot_r == '0) ? LastSlot : tail_slot_r - AW'(1);
  assign tail_dec_lap  = (tail_slot_r == '0) ? ~tail_lap_r : tail_lap_r;
  assign head_inc_slot = (head_slot_r == LastSlot) ? '0 : head_slot_r + AW'(1);
  assign head_inc_lap  = (head_slot_r == LastSlot) ? ~head_lap_r : head_lap_r;

  always_comb begin
    req.wr_en     = 1'b0;
    req.rd_en     = 1'b0;
    req.status    = ST_OK;
    addr          = tail_slot_r;
    fill_after    = fill;
    head_slot_nxt = head_slot_r;
    head_lap_nxt  = head_lap_r;
    tail_slot_nxt = tail_slot_r;
    tail_lap_nxt  = tail_lap_r;
    unique case (func)
      OP_PUT: begin
        if (full) begin
          req.status = ST_FULL;
        end else begin
          req.wr_en     = op_valid;
          fill_after    = fill + FW'(1);
          tail_slot_nxt = tail_inc_slot;
          tail_lap_nxt  = tail_inc_lap;
        end
      end
      OP_TAKE: begin
        addr = tail_dec_slot;
        if (empty) begin
          req.status = ST_EMPTY;
        end else begin
          req.rd_en     = op_valid;
          fill_after    = fill - FW'(1);
          tail_slot_nxt = tail_dec_slot;
          tail_lap_nxt  = tail_dec_lap;
        end
      end
      OP_STEAL: begin
        addr = head_slot_r;
        if (empty) begin
          req.status = ST_EMPTY;
        end else begin
          req.rd_en     = op_valid;
          fill_after    = fill - FW'(1);
          head_slot_nxt = head_inc_slot;
          head_lap_nxt  = head_inc_lap;
        end
      end
      OP_NONE: begin
        req.status = ST_OK;
      end
      default: begin
        req.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_slot_r <= '0;
      head_lap_r  <= 1'b0;
      tail_slot_r <= '0;
      tail_lap_r  <= 1'b0;
    end else if (op_valid) begin
      head_slot_r <= head_slot_nxt;
      head_lap_r  <= head_lap_nxt;
      tail_slot_r <= tail_slot_nxt;
      tail_lap_r  <= tail_lap_nxt;
    end
  end

endmodule

@@ rtl/core/work_stealing_deque_unit.sv @@
// Work-stealing deque of task handles: puts and takes at the tail, steals at the head.
// A result is offered in the cycle after its item is accepted.
// Throughput: one item per cycle unless stalled; one RAM port, at most one access per item.
// A stalled result holds in the output register and the RAM read register.
// Reset clears the head and tail indexes and the output valid; slot contents are not cleared.
module work_stealing_deque_unit #(
  parameter int DEPTH       = 32,
  parameter int ENTRY_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wsd_pkg::IN_DATA_W-1:0]  in_tdata,  // [63:0] task_word
  input  logic [wsd_pkg::FUNC_W-1:0]     in_tuser,  // [1:0] func
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wsd_pkg::OUT_DATA_W-1:0] out_tdata, // [63:0] task_out, [69:64] fill_count
  output logic [wsd_pkg::STATUS_W-1:0]   out_tuser  // [1:0] status
);
  import wsd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic                   accept;
  wsd_req_t               req;
  logic [AW-1:0]          addr;
  logic [FW-1:0]          fill_after;
  logic [ENTRY_WIDTH-1:0] rdata;
  logic [TASK_W-1:0]      task_out;

  logic                  out_valid_r;
  status_t               status_r;
  logic [FILL_OUT_W-1:0] fill_r;
  logic                  from_ram_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  wsd_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .FW   (FW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (accept),
    .func      (func_t'(in_tuser)),
    .req       (req),
    .addr      (addr),
    .fill_after(fill_after)
  );

  wsd_ram #(
    .WIDTH(ENTRY_WIDTH),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (req.wr_en),
    .re   (req.rd_en),
    .addr (addr),
    .wdata(in_tdata[ENTRY_WIDTH-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= req.status;
      fill_r     <= FILL_OUT_W'(fill_after);
      from_ram_r <= req.rd_en;
    end
  end

  // The handle is the RAM read register, which holds while stalled, or zero after no read.
  assign task_out   = from_ram_r ? TASK_W'(rdata) : '0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - FILL_OUT_W - TASK_W)'(0), fill_r, task_out};
  assign out_tuser  = status_r;

endmodule

@@ tb/wsd_checker.sv @@
// Checker for the work-stealing deque unit: tracks the deque and compares every result.
`timescale 1ns / 1ps

module wsd_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [wsd_pkg::IN_DATA_W-1:0]  in_tdata,  // [63:0] task_word
  input  logic [wsd_pkg::FUNC_W-1:0]     in_tuser,  // [1:0] func
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [wsd_pkg::OUT_DATA_W-1:0] out_tdata, // [63:0] task_out, [69:64] fill_count
  input  logic [wsd_pkg::STATUS_W-1:0]   out_tuser, // [1:0] status
  output int                             fail_count,
  output int                             results_owed
);
  import wsd_pkg::*;

  localparam int SLOTS     = 32;
  localparam int IDX_RANGE = 2 * SLOTS;

  typedef struct packed {
    status_t                 status;
    logic [TASK_W-1:0]       handle;
    logic [FILL_OUT_W-1:0]   fill;
  } deque_result_t;

  logic [TASK_W-1:0] slots [SLOTS];
  int                head_pos;
  int                tail_pos;
  deque_result_t     owed_q[$];
  int                mismatches = 0;
  int                owed_now   = 0;

  assign fail_count   = mismatches;
  assign results_owed = owed_now;

  // Indexes run modulo twice the depth so that full and empty differ.
  function automatic deque_result_t apply_deque_op(func_t op, logic [TASK_W-1:0] word);
    deque_result_t r;
    int            fill;
    fill     = (tail_pos - head_pos + IDX_RANGE) % IDX_RANGE;
    r.status = ST_OK;
    r.handle = '0;
    case (op)
      OP_PUT: begin
        if (fill >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          slots[tail_pos % SLOTS] = word;
          tail_pos = (tail_pos + 1) % IDX_RANGE;
        end
      end
      OP_TAKE: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          tail_pos = (tail_pos + IDX_RANGE - 1) % IDX_RANGE;
          r.handle = slots[tail_pos % SLOTS];
        end
      end
      OP_STEAL: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.handle = slots[head_pos % SLOTS];
          head_pos = (head_pos + 1) % IDX_RANGE;
        end
      end
      default: ;
    endcase
    r.fill = FILL_OUT_W'((tail_pos - head_pos + IDX_RANGE) % IDX_RANGE);
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [TASK_W-1:0] want, logic [TASK_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      head_pos = 0;
      tail_pos = 0;
      owed_q.delete();
    end else begin
      // The result leaving now always belongs to an older item than one entering now.
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          flag_mismatch("unexpected result, task_out", '0, out_tdata[TASK_W-1:0]);
        end else begin
          want = owed_q.pop_front();
          if (out_tuser !== want.status)
            flag_mismatch("status", TASK_W'(want.status), TASK_W'(out_tuser));
          if (out_tdata[TASK_W-1:0] !== want.handle)
            flag_mismatch("task_out", want.handle, out_tdata[TASK_W-1:0]);
          if (out_tdata[TASK_W +: FILL_OUT_W] !== want.fill)
            flag_mismatch("fill_count", TASK_W'(want.fill),
                          TASK_W'(out_tdata[TASK_W +: FILL_OUT_W]));
          if (out_tdata[OUT_DATA_W-1:TASK_W+FILL_OUT_W] !== '0)
            flag_mismatch("tdata padding", '0,
                          TASK_W'(out_tdata[OUT_DATA_W-1:TASK_W+FILL_OUT_W]));
        end
      end
      if (in_tvalid && in_tready) begin
        owed_q.push_back(apply_deque_op(func_t'(in_tuser), in_tdata[TASK_W-1:0]));
      end
    end
    owed_now <= owed_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the testbench: clock, reset, stimulus and handshake pacing for the deque unit.
`timescale 1ns / 1ps

module testbench;
  import wsd_pkg::*;

  localparam int ITEM_TARGET  = 1250;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 200;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  int fail_count;
  int results_owed;
  int items_sent    = 0;
  int results_taken = 0;
  int idle_cycles   = 0;
  bit quiet_phase   = 1'b0;

  always #5 clk = ~clk;

  work_stealing_deque_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  wsd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // Called just after a falling edge; returns just after the falling edge past acceptance.
  task automatic offer_item(func_t op, logic [IN_DATA_W-1:0] word);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [IN_DATA_W-1:0] random_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int    seg_len;
    int    put_pct;
    int    pick;
    func_t op;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_NONE;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Empty store, the unused code, extreme handles, then LIFO and FIFO order.
    offer_item(OP_TAKE, '0);
    offer_item(OP_STEAL, '1);
    offer_item(OP_NONE, '1);
    offer_item(OP_PUT, '0);
    offer_item(OP_PUT, '1);
    offer_item(OP_PUT, 64'h5555_5555_5555_5555);
    offer_item(OP_PUT, 64'hAAAA_AAAA_AAAA_AAAA);
    offer_item(OP_NONE, 64'h1234_5678_9ABC_DEF0);
    offer_item(OP_TAKE, '0);
    offer_item(OP_STEAL, '0);
    offer_item(OP_STEAL, '0);
    offer_item(OP_TAKE, '0);
    offer_item(OP_TAKE, '0);
    offer_item(OP_STEAL, '0);
    offer_item(OP_PUT, 64'h8000_0000_0000_0001);
    offer_item(OP_STEAL, '0);

    // The first burst holds only puts and the unused code, so that the store fills and refuses a put early on.
    put_pct = 100;
    seg_len = 36;
    while (items_sent < ITEM_TARGET) begin
      repeat (seg_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          op = OP_NONE;
        end else if (pick < put_pct) begin
          op = OP_PUT;
        end else begin
          op = $urandom_range(0, 1) ? OP_TAKE : OP_STEAL;
        end
        offer_item(op, random_handle());
      end
      seg_len     = $urandom_range(20, 80);
      put_pct     = 20 + 30 * $urandom_range(0, 2);
      quiet_phase = ($urandom_range(0, 3) == 0);
    end
    in_tvalid <= 1'b0;

    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("[work_stealing_deque_unit] OK");
    end else begin
      $display("[work_stealing_deque_unit] ERROR");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that backs the block up to its input.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 4);
      if (results_taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) begin
          $display("[work_stealing_deque_unit] ERROR");
          $finish;
        end
      end
    end
  end

endmodule
